// ===== sv/sfma_pkg.sv =====
// Shared constants, types and tables for the spectrum frame moving average.
package sfma_pkg;

	// Frame geometry and sample format
	localparam int BINS_PER_FRAME    = 1024;
	localparam int POS_W             = $clog2(BINS_PER_FRAME);
	localparam int MAX_WINDOW_FRAMES = 16;
	localparam int WIN_W             = $clog2(MAX_WINDOW_FRAMES + 1);
	localparam int SLOT_W            = $clog2(MAX_WINDOW_FRAMES);
	localparam int SAMPLE_BITS       = 16;

	// Running sum, history address and divider widths
	localparam int SUM_W       = SAMPLE_BITS + SLOT_W;
	localparam int HIST_AW     = SLOT_W + POS_W;
	localparam int HIST_DEPTH  = MAX_WINDOW_FRAMES * BINS_PER_FRAME;
	localparam int T_W         = SUM_W + 1;
	localparam int RECIP_SHIFT = T_W + WIN_W;
	localparam int RECIP_W     = RECIP_SHIFT;
	localparam int PROD_W      = T_W + RECIP_W;
	localparam int Q_W         = SAMPLE_BITS + 1;

	// APB port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	// Register map (index = paddr[2])
	typedef enum logic {
		REG_AVERAGING_ON  = 1'b0,
		REG_WINDOW_FRAMES = 1'b1
	} cfg_reg_t;

	// Input item kinds
	typedef enum logic {
		ACT_BIN   = 1'b0,
		ACT_CLEAR = 1'b1
	} action_t;

	// Per-bin descriptor from frame bookkeeping to the accumulator
	typedef struct packed {
		logic              mode;
		logic [WIN_W-1:0]  held;
		logic              evicts;
		logic [SLOT_W-1:0] slot;
		logic [POS_W-1:0]  pos;
		logic              fend;
	} bin_ctl_t;

	// Accumulator result handed to the averaging stages
	typedef struct packed {
		logic                          mode;
		logic [WIN_W-1:0]              held;
		logic [POS_W-1:0]              pos;
		logic                          fend;
		logic signed [SAMPLE_BITS-1:0] x;
		logic signed [SUM_W-1:0]       sum;
	} acc_t;

	// Reciprocals ceil(2^RECIP_SHIFT / (2n)) for n = 1..16, exact for t < 2^T_W
	localparam longint RECIP_ONE = 64'd1 << RECIP_SHIFT;
	localparam logic [RECIP_W-1:0] RECIP_TABLE [MAX_WINDOW_FRAMES] = '{
		RECIP_W'((RECIP_ONE + 1)  / 2),
		RECIP_W'((RECIP_ONE + 3)  / 4),
		RECIP_W'((RECIP_ONE + 5)  / 6),
		RECIP_W'((RECIP_ONE + 7)  / 8),
		RECIP_W'((RECIP_ONE + 9)  / 10),
		RECIP_W'((RECIP_ONE + 11) / 12),
		RECIP_W'((RECIP_ONE + 13) / 14),
		RECIP_W'((RECIP_ONE + 15) / 16),
		RECIP_W'((RECIP_ONE + 17) / 18),
		RECIP_W'((RECIP_ONE + 19) / 20),
		RECIP_W'((RECIP_ONE + 21) / 22),
		RECIP_W'((RECIP_ONE + 23) / 24),
		RECIP_W'((RECIP_ONE + 25) / 26),
		RECIP_W'((RECIP_ONE + 27) / 28),
		RECIP_W'((RECIP_ONE + 29) / 30),
		RECIP_W'((RECIP_ONE + 31) / 32)
	};

endpackage

// ===== sv/sfma_in_if.sv =====
// Input channel: one bin or a clear action per transfer.
interface sfma_in_if import sfma_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic                          action;
	logic signed [SAMPLE_BITS-1:0] bin_value;

	modport source (output valid, action, bin_value, input ready);
	modport sink   (input valid, action, bin_value, output ready);
endinterface

// ===== sv/sfma_out_if.sv =====
// Output channel: one averaged or passed-through bin per transfer.
interface sfma_out_if import sfma_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] bin_result;
	logic [POS_W-1:0]              bin_number;
	logic                          frame_end;

	modport source (output valid, bin_result, bin_number, frame_end, input ready);
	modport sink   (input valid, bin_result, bin_number, frame_end, output ready);
endinterface

// ===== sv/spectrum_frame_moving_average.sv =====
// Top level of the per-bin sliding-window spectrum average.
// Takes one transfer per clock and sustains one bin per cycle while the output
// is not stalled; a bin passes five register stages (two accumulator stages, two
// divider stages, output register), and its result is held in the output
// register until a clock edge with ready high. Downstream stalls back up through the
// stage valids, and empty stages fill while the output waits. Clear actions
// are taken at the same rate and produce no result. The history ring
// (16384 x 16) and per-bin sums (1024 x 20) sit in single-write memories;
// they need no clearing pass, as the frame count guarantees every entry read
// was written first. Write configuration only while the pipeline is empty.
module spectrum_frame_moving_average import sfma_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	sfma_in_if.sink           bin_in,
	sfma_out_if.source        bin_out,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	logic     acc_rdy;
	logic     bin_take;
	logic     clr_take;
	bin_ctl_t ctl;
	logic     acc_valid;
	acc_t     acc;
	logic     acc_ready;

	// Input transfer decode
	assign bin_in.ready = acc_rdy;
	assign bin_take = bin_in.valid && acc_rdy && (action_t'(bin_in.action) == ACT_BIN);
	assign clr_take = bin_in.valid && acc_rdy && (action_t'(bin_in.action) == ACT_CLEAR);

	sfma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.bin_take (bin_take),
		.clr_take (clr_take),
		.ctl      (ctl)
	);

	sfma_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (bin_take),
		.ctl       (ctl),
		.x         (bin_in.bin_value),
		.ready     (acc_rdy),
		.acc_valid (acc_valid),
		.acc       (acc),
		.acc_ready (acc_ready)
	);

	sfma_avg u_avg (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc_valid (acc_valid),
		.acc       (acc),
		.acc_ready (acc_ready),
		.res_valid (bin_out.valid),
		.res_ready (bin_out.ready),
		.res_value (bin_out.bin_result),
		.res_pos   (bin_out.bin_number),
		.res_fend  (bin_out.frame_end)
	);

endmodule

// ===== sv/sfma_ctrl.sv =====
// Register file and frame bookkeeping: bin position, frames held, ring slot.
module sfma_ctrl import sfma_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	input  logic              bin_take,
	input  logic              clr_take,
	output bin_ctl_t          ctl
);

	logic              on_q;
	logic [WIN_W-1:0]  win_q;
	logic [WIN_W-1:0]  held_q;
	logic [SLOT_W-1:0] slot_q;
	logic [POS_W-1:0]  pos_q;
	logic              mode_q;
	logic              evicts_q;
	logic              wr_en;
	cfg_reg_t          reg_sel;
	logic [WIN_W-1:0]  win_sat;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = cfg_reg_t'(paddr[2]);

	// Window saturates to 1..MAX_WINDOW_FRAMES
	always_comb begin
		win_sat = pwdata[WIN_W-1:0];
		if (win_sat == '0) begin
			win_sat = WIN_W'(1);
		end else if (win_sat > WIN_W'(MAX_WINDOW_FRAMES)) begin
			win_sat = WIN_W'(MAX_WINDOW_FRAMES);
		end
	end

	// Register readback
	always_comb begin
		case (reg_sel)
			REG_AVERAGING_ON:  prdata = APB_DW'(on_q);
			REG_WINDOW_FRAMES: prdata = APB_DW'(win_q);
			default:           prdata = '0;
		endcase
	end

	// Descriptor of the bin now at the input; frame state advances at bin zero
	always_comb begin
		ctl.mode   = mode_q;
		ctl.held   = held_q;
		ctl.evicts = evicts_q;
		ctl.slot   = slot_q;
		ctl.pos    = pos_q;
		ctl.fend   = (pos_q == POS_W'(BINS_PER_FRAME - 1));
		if (pos_q == '0) begin
			ctl.mode = on_q;
			if (on_q) begin
				if (held_q < win_q) begin
					ctl.held   = held_q + 1'b1;
					ctl.slot   = held_q[SLOT_W-1:0];
					ctl.evicts = 1'b0;
				end else begin
					ctl.slot   = ({1'b0, slot_q} == win_q - 1'b1) ? '0 : slot_q + 1'b1;
					ctl.evicts = 1'b1;
				end
			end
		end
	end

	// Config registers and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_q     <= 1'b0;
			win_q    <= WIN_W'(1);
			held_q   <= '0;
			slot_q   <= '0;
			pos_q    <= '0;
			mode_q   <= 1'b0;
			evicts_q <= 1'b0;
		end else begin
			if (wr_en && reg_sel == REG_AVERAGING_ON) begin
				on_q <= pwdata[0];
			end
			if ((wr_en && reg_sel == REG_WINDOW_FRAMES) || clr_take) begin
				// window change or clear action: history restarts
				held_q   <= '0;
				slot_q   <= '0;
				pos_q    <= '0;
				mode_q   <= 1'b0;
				evicts_q <= 1'b0;
			end else if (bin_take) begin
				held_q   <= ctl.held;
				slot_q   <= ctl.slot;
				mode_q   <= ctl.mode;
				evicts_q <= ctl.evicts;
				pos_q    <= ctl.fend ? '0 : pos_q + 1'b1;
			end
			if (wr_en && reg_sel == REG_WINDOW_FRAMES) begin
				win_q <= win_sat;
			end
		end
	end

	// Frame count never passes the window
	a_held_le_win: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= win_q)
		else $error("frames held exceeds window");

	// Newest slot lies among the frames held
	a_slot_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		held_q != '0 |-> {1'b0, slot_q} < held_q)
		else $error("ring slot outside held frames");

	// Eviction only with a full window
	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		evicts_q |-> held_q == win_q)
		else $error("eviction before window filled");

endmodule

// ===== sv/sfma_accum.sv =====
// Stages 1-2: history ring and per-bin sum memories, running sum update.
module sfma_accum import sfma_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  bin_ctl_t                      ctl,
	input  logic signed [SAMPLE_BITS-1:0] x,
	output logic                          ready,
	output logic                          acc_valid,
	output acc_t                          acc,
	input  logic                          acc_ready
);

	logic signed [SAMPLE_BITS-1:0] hist_mem [HIST_DEPTH];
	logic signed [SUM_W-1:0]       sum_mem  [BINS_PER_FRAME];

	logic                          v_s1;
	bin_ctl_t                      ctl_s1;
	logic signed [SAMPLE_BITS-1:0] x_s1;
	logic signed [SAMPLE_BITS-1:0] hist_rd_s1;
	logic signed [SUM_W-1:0]       sum_rd_s1;
	logic signed [SUM_W:0]         sum_w;
	logic signed [SUM_W-1:0]       sum_new;
	logic                          v_s2;
	logic                          rdy_s1;
	logic                          rdy_s2;

	assign rdy_s2    = !v_s2 || acc_ready;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign ready     = rdy_s1;
	assign acc_valid = v_s2;

	// New running sum: a single frame held starts fresh, full window drops the oldest
	always_comb begin
		if (ctl_s1.held <= WIN_W'(1)) begin
			sum_w = (SUM_W+1)'(x_s1);
		end else if (ctl_s1.evicts) begin
			sum_w = (SUM_W+1)'(sum_rd_s1) + (SUM_W+1)'(x_s1) - (SUM_W+1)'(hist_rd_s1);
		end else begin
			sum_w = (SUM_W+1)'(sum_rd_s1) + (SUM_W+1)'(x_s1);
		end
		sum_new = sum_w[SUM_W-1:0];
	end

	// Memory reads at transfer, writes as an averaged bin leaves stage 1
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			hist_rd_s1 <= hist_mem[{ctl.slot, ctl.pos}];
			sum_rd_s1  <= sum_mem[ctl.pos];
		end
		if (v_s1 && rdy_s2 && ctl_s1.mode) begin
			hist_mem[{ctl_s1.slot, ctl_s1.pos}] <= x_s1;
			sum_mem[ctl_s1.pos]                 <= sum_new;
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= load;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			ctl_s1 <= ctl;
			x_s1   <= x;
		end
		if (rdy_s2) begin
			acc.mode <= ctl_s1.mode;
			acc.held <= ctl_s1.held;
			acc.pos  <= ctl_s1.pos;
			acc.fend <= ctl_s1.fend;
			acc.x    <= x_s1;
			acc.sum  <= sum_new;
		end
	end

endmodule

// ===== sv/sfma_avg.sv =====
// Stages 3-5: rounded division of the sum by frames held or pass-through, output register.
module sfma_avg import sfma_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          acc_valid,
	input  acc_t                          acc,
	output logic                          acc_ready,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic signed [SAMPLE_BITS-1:0] res_value,
	output logic [POS_W-1:0]              res_pos,
	output logic                          res_fend
);

	logic                          v_s3;
	logic                          v_s4;
	logic                          v_s5;
	logic                          rdy_s3;
	logic                          rdy_s4;
	logic                          rdy_s5;
	logic                          mode_s3;
	logic                          mode_s4;
	logic                          neg_s3;
	logic                          neg_s4;
	logic [T_W-1:0]                t_s3;
	logic [RECIP_W-1:0]            recip_s3;
	logic [Q_W-1:0]                q_s4;
	logic signed [SAMPLE_BITS-1:0] x_s3;
	logic signed [SAMPLE_BITS-1:0] x_s4;
	logic [POS_W-1:0]              pos_s3;
	logic [POS_W-1:0]              pos_s4;
	logic                          fend_s3;
	logic                          fend_s4;
	logic [SUM_W-1:0]              mag;
	logic [PROD_W-1:0]             prod;
	logic [Q_W-1:0]                q_signed;

	assign rdy_s5    = !v_s5 || res_ready;
	assign rdy_s4    = !v_s4 || rdy_s5;
	assign rdy_s3    = !v_s3 || rdy_s4;
	assign acc_ready = rdy_s3;
	assign res_valid = v_s5;

	// Magnitude of the sum; rounding term 2*|sum| + n
	assign mag = acc.sum[SUM_W-1] ? SUM_W'(-acc.sum) : SUM_W'(acc.sum);

	// Quotient by reciprocal multiply
	assign prod = PROD_W'(t_s3) * PROD_W'(recip_s3);

	// Sign restored on the rounded quotient
	assign q_signed = neg_s4 ? Q_W'(-q_s4) : q_s4;

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s3) begin
				v_s3 <= acc_valid;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
			if (rdy_s5) begin
				v_s5 <= v_s4;
			end
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			mode_s3  <= acc.mode;
			neg_s3   <= acc.sum[SUM_W-1];
			t_s3     <= {mag, 1'b0} + T_W'(acc.held);
			recip_s3 <= RECIP_TABLE[SLOT_W'(acc.held - 1'b1)];
			x_s3     <= acc.x;
			pos_s3   <= acc.pos;
			fend_s3  <= acc.fend;
		end
		if (rdy_s4) begin
			mode_s4 <= mode_s3;
			neg_s4  <= neg_s3;
			q_s4    <= prod[RECIP_SHIFT +: Q_W];
			x_s4    <= x_s3;
			pos_s4  <= pos_s3;
			fend_s4 <= fend_s3;
		end
		if (rdy_s5) begin
			res_value <= mode_s4 ? q_signed[SAMPLE_BITS-1:0] : x_s4;
			res_pos   <= pos_s4;
			res_fend  <= fend_s4;
		end
	end

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the spectrum frame moving average: directed and random frames.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import sfma_pkg::*;

	localparam int PIPE_SLACK  = 8;
	localparam int RANDOM_BINS = 160;
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	// Content of a frame of bins
	typedef enum {FILL_ANY, FILL_MIXED, FILL_SMALL, FILL_MAX, FILL_MIN} fill_t;

	// Receiver ready patterns
	typedef enum {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] value;
		logic [POS_W-1:0]              number;
		logic                          frame_end;
	} bin_out_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	sfma_in_if  bin_in ();
	sfma_out_if bin_out ();

	spectrum_frame_moving_average uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.bin_in  (bin_in),
		.bin_out (bin_out),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Predicted outputs, oldest first
	bin_out_t predicted_bins[$];

	// Mirror of the block's registers and averaging state
	logic                          avg_on;
	int                            window_len;
	logic signed [SAMPLE_BITS-1:0] history [HIST_DEPTH];
	int                            bin_sum [BINS_PER_FRAME];
	int                            next_pos;
	int                            held_frames;
	int                            newest;
	bit                            frame_avg;
	bit                            frame_replaces;

	int    mismatches = 0;
	int    burst_left = 0;
	fill_t cur_fill   = FILL_MIXED;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void note_mismatch(string what, int want, int got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $time);
		end
	endfunction

	function automatic void restart_history();
		next_pos       = 0;
		held_frames    = 0;
		newest         = 0;
		frame_avg      = 1'b0;
		frame_replaces = 1'b0;
	endfunction

	// sum / n rounded to nearest, halves away from zero
	function automatic int round_avg(int total, int n);
		int mag;
		int q;
		mag = (total < 0) ? -total : total;
		q   = (2 * mag + n) / (2 * n);
		return (total < 0) ? -q : q;
	endfunction

	// Advance the mirror by one bin and queue the output it should give
	function automatic void accumulate_bin(logic signed [SAMPLE_BITS-1:0] x);
		int       total;
		int       idx;
		bin_out_t r;
		// mode and ring slot are fixed at bin zero
		if (next_pos == 0) begin
			frame_avg = avg_on;
			if (frame_avg) begin
				if (held_frames < window_len) begin
					held_frames++;
					newest         = held_frames - 1;
					frame_replaces = 1'b0;
				end else begin
					newest         = (newest + 1) % window_len;
					frame_replaces = 1'b1;
				end
			end
		end
		r.value = x;
		if (frame_avg) begin
			idx = newest * BINS_PER_FRAME + next_pos;
			if (held_frames <= 1) total = x;
			else if (frame_replaces) total = bin_sum[next_pos] + x - history[idx];
			else total = bin_sum[next_pos] + x;
			bin_sum[next_pos] = total;
			history[idx]      = x;
			r.value           = SAMPLE_BITS'(round_avg(total, held_frames));
		end
		r.number    = POS_W'(next_pos);
		r.frame_end = (next_pos == BINS_PER_FRAME - 1);
		predicted_bins = {predicted_bins, r};
		next_pos = (next_pos + 1) % BINS_PER_FRAME;
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] fill_value(fill_t f);
		logic signed [SAMPLE_BITS-1:0] v;
		v = SAMPLE_BITS'($urandom);
		case (f)
			FILL_SMALL: v = SAMPLE_BITS'(int'($urandom_range(0, 8)) - 4);
			FILL_MAX:   v = SAMPLE_MAX;
			FILL_MIN:   v = SAMPLE_MIN;
			default: begin
				case ($urandom_range(0, 9))
					0: v = SAMPLE_MAX;
					1: v = SAMPLE_MIN;
					2: v = SAMPLE_BITS'(int'($urandom_range(0, 8)) - 4);
					default: ;
				endcase
			end
		endcase
		return v;
	endfunction

	// One APB transfer: setup phase, access phase, then idle
	task automatic apb_transfer(cfg_reg_t idx, bit wr, logic [APB_DW-1:0] wdata,
			output logic [APB_DW-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= APB_AW'({idx, 2'b00});
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_reg(cfg_reg_t idx);
		logic [APB_DW-1:0] rd;
		apb_transfer(idx, 1'b0, '0, rd);
		if (idx == REG_AVERAGING_ON) begin
			if (rd[0] !== avg_on) note_mismatch("averaging_on readback", avg_on, rd[0]);
		end else begin
			if (rd[WIN_W-1:0] !== WIN_W'(window_len)) begin
				note_mismatch("window_frames readback", window_len, rd[WIN_W-1:0]);
			end
		end
	endtask

	// Write a register, mirror it, read it back
	task automatic set_reg(cfg_reg_t idx, logic [APB_DW-1:0] data);
		logic [APB_DW-1:0] rd;
		int                w;
		apb_transfer(idx, 1'b1, data, rd);
		if (idx == REG_AVERAGING_ON) begin
			avg_on = data[0];
		end else begin
			w          = data[4:0];
			window_len = (w < 1) ? 1 : (w > MAX_WINDOW_FRAMES) ? MAX_WINDOW_FRAMES : w;
			restart_history();
		end
		check_reg(idx);
	endtask

	// One input transfer, then the sender's burst/gap bookkeeping
	task automatic send_item(action_t act, logic signed [SAMPLE_BITS-1:0] val);
		int gap;
		bin_in.valid     <= 1'b1;
		bin_in.action    <= act;
		bin_in.bin_value <= val;
		// ready as seen at the edge itself
		@(posedge clk iff (bin_in.ready === 1'b1));
		if (act == ACT_CLEAR) restart_history();
		else accumulate_bin(val);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				bin_in.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
			                                         : $urandom_range(0, 20);
		end
	endtask

	// A fixed fill holds for the whole call; FILL_ANY picks one per frame
	task automatic send_bins(int count, fill_t fill);
		for (int i = 0; i < count; i++) begin
			if (fill != FILL_ANY) begin
				cur_fill = fill;
			end else if (next_pos == 0) begin
				if ($urandom_range(0, 1)) cur_fill = FILL_MIXED;
				else cur_fill = fill_t'($urandom_range(FILL_MIXED, FILL_MIN));
			end
			send_item(ACT_BIN, fill_value(cur_fill));
		end
	endtask

	// Complete the current frame and n-1 more
	task automatic finish_frames(int n, fill_t fill);
		send_bins(n * BINS_PER_FRAME - next_pos, fill);
	endtask

	// Stop sending and let every pending result and clear work through
	task automatic drain();
		bin_in.valid <= 1'b0;
		@(posedge clk);
		while (predicted_bins.size() != 0) @(posedge clk);
		repeat (PIPE_SLACK) @(posedge clk);
	endtask

	// Reset values, then pass-through of the sample extremes and a clear
	task automatic test_passthrough_extremes();
		check_reg(REG_AVERAGING_ON);
		check_reg(REG_WINDOW_FRAMES);
		send_item(ACT_BIN, SAMPLE_MAX);
		send_item(ACT_BIN, SAMPLE_MIN);
		send_item(ACT_BIN, 16'sh0000);
		send_item(ACT_BIN, -16'sd1);
		send_item(ACT_BIN, 16'sd1);
		send_item(ACT_BIN, 16'sh5555);
		send_item(ACT_BIN, 16'shAAAA);
		send_item(ACT_CLEAR, SAMPLE_BITS'($urandom));
		send_item(ACT_BIN, 16'sh00FF);
		send_item(ACT_BIN, 16'shFF00);
		drain();
	endtask

	// Window saturation, ignored upper bits, restart on window write
	task automatic test_register_writes();
		set_reg(REG_WINDOW_FRAMES, 32'd0);
		set_reg(REG_WINDOW_FRAMES, 32'd31);
		set_reg(REG_WINDOW_FRAMES, 32'hFFFF_FFF0);
		set_reg(REG_WINDOW_FRAMES, 32'd17);
		set_reg(REG_AVERAGING_ON, 32'hFFFF_FFFE);
		set_reg(REG_AVERAGING_ON, 32'h8000_0001);
		set_reg(REG_WINDOW_FRAMES, 32'd1);
		send_item(ACT_BIN, SAMPLE_MIN);
		send_item(ACT_BIN, SAMPLE_MAX);
		send_item(ACT_BIN, -16'sd3);
		drain();
		// a write in the middle of a frame restarts at bin zero
		set_reg(REG_WINDOW_FRAMES, 32'd0);
		send_item(ACT_BIN, 16'sd7);
		send_item(ACT_BIN, -16'sd7);
		drain();
	endtask

	// Window of two: sums at both ends of the range, small values for halfway cases
	task automatic test_rounding();
		set_reg(REG_AVERAGING_ON, 32'd1);
		set_reg(REG_WINDOW_FRAMES, 32'd2);
		// first frame: extremes in the low bins, small values after
		send_bins(50, FILL_MIN);
		send_bins(50, FILL_MAX);
		finish_frames(1, FILL_SMALL);
		// second frame averages against the first
		send_bins(50, FILL_MIN);
		send_bins(50, FILL_MAX);
		send_bins(250, FILL_SMALL);
		drain();
	endtask

	// Averaging on/off only takes effect at the next bin zero
	task automatic test_mode_toggle();
		// switched off mid-frame: the rest of this frame stays averaged
		set_reg(REG_AVERAGING_ON, 32'd0);
		send_bins(100, FILL_ANY);
		// a clear starts a fresh frame, now passed through
		send_item(ACT_CLEAR, SAMPLE_BITS'($urandom));
		send_bins(100, FILL_ANY);
		drain();
		// switched on mid-frame: still passed through until the next bin zero
		set_reg(REG_AVERAGING_ON, 32'd1);
		send_bins(100, FILL_ANY);
		send_item(ACT_CLEAR, SAMPLE_BITS'($urandom));
		send_bins(50, FILL_ANY);
		drain();
	endtask

	// Random short spans of bins with random window, mode changes and stray clears
	task automatic test_random_phases();
		int sent;
		int span;
		sent = 0;
		while (sent < RANDOM_BINS) begin
			if ($urandom_range(0, 2) == 0) begin
				drain();
				if ($urandom_range(0, 1)) begin
					set_reg(REG_WINDOW_FRAMES, ($urandom_range(0, 3) == 0) ? $urandom
					                                                     : $urandom_range(1, 4));
				end else begin
					set_reg(REG_AVERAGING_ON, $urandom);
				end
			end
			if ($urandom_range(0, 7) == 0) send_item(ACT_CLEAR, SAMPLE_BITS'($urandom));
			span = $urandom_range(1, 64);
			send_bins(span, FILL_ANY);
			sent += span;
		end
	endtask

	// Stimulus
	initial begin
		arst_n           <= 1'b0;
		psel             <= 1'b0;
		penable          <= 1'b0;
		pwrite           <= 1'b0;
		paddr            <= '0;
		pwdata           <= '0;
		bin_in.valid     <= 1'b0;
		bin_in.action    <= ACT_BIN;
		bin_in.bin_value <= '0;
		avg_on     = 1'b0;
		window_len = 1;
		restart_history();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_passthrough_extremes();
		test_register_writes();
		test_rounding();
		test_mode_toggle();
		test_random_phases();
		drain();
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Receiver: picks a new random ready pattern whenever the current one runs out
	initial begin
		stall_t mode;
		int     left;
		bin_out.ready <= 1'b0;
		mode = STALL_NONE;
		left = 0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				mode = stall_t'($urandom_range(STALL_NONE, STALL_HEAVY));
				left = $urandom_range(20, 300);
			end
			left--;
			case (mode)
				STALL_NONE:     bin_out.ready <= 1'b1;
				STALL_LIGHT:    bin_out.ready <= ($urandom_range(0, 3) != 0);
				STALL_PERIODIC: bin_out.ready <= ((left % 5) != 0);
				default:        bin_out.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Compare each output transfer with the oldest prediction
	always @(posedge clk) begin : check_results
		bin_out_t want;
		if (arst_n && bin_out.valid && bin_out.ready) begin
			if (predicted_bins.size() == 0) begin
				note_mismatch("bin_result with no bin pending", 0, bin_out.bin_result);
			end else begin
				want = predicted_bins[0];
				predicted_bins.delete(0);
				if (bin_out.bin_result !== want.value) begin
					note_mismatch("bin_result", want.value, bin_out.bin_result);
				end
				if (bin_out.bin_number !== want.number) begin
					note_mismatch("bin_number", want.number, bin_out.bin_number);
				end
				if (bin_out.frame_end !== want.frame_end) begin
					note_mismatch("frame_end", want.frame_end, bin_out.frame_end);
				end
			end
		end
	end

	// Hang guard
	initial begin
		#1ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule
